FILE: design/dts_pkg.sv
// Package for the Datalog token scanner: beat structs, scan modes, token kinds,
// character codes and keyword tables. It depends on nothing else.
`default_nettype none
package dts_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] line_number;
      logic [15:0] token_length;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] num;
      rsp_type    tok0;
      rsp_type    tok1;
   } push_type;

   typedef enum logic [3:0] {
      MODE_IDLE  = 4'd0,
      MODE_COLON = 4'd1,
      MODE_ID    = 4'd2,
      MODE_HASH  = 4'd3,
      MODE_LINE  = 4'd4,
      MODE_BLOCK = 4'd5,
      MODE_BAR   = 4'd6,
      MODE_STR   = 4'd7,
      MODE_QUOTE = 4'd8
   } mode_type;

   localparam logic [4:0] KIND_COMMA     = 5'd0;
   localparam logic [4:0] KIND_PERIOD    = 5'd1;
   localparam logic [4:0] KIND_QMARK     = 5'd2;
   localparam logic [4:0] KIND_LPAREN    = 5'd3;
   localparam logic [4:0] KIND_RPAREN    = 5'd4;
   localparam logic [4:0] KIND_COLON     = 5'd5;
   localparam logic [4:0] KIND_COLONDASH = 5'd6;
   localparam logic [4:0] KIND_MUL       = 5'd7;
   localparam logic [4:0] KIND_ADD       = 5'd8;
   localparam logic [4:0] KIND_SCHEMES   = 5'd9;
   localparam logic [4:0] KIND_ID        = 5'd13;
   localparam logic [4:0] KIND_STRING    = 5'd14;
   localparam logic [4:0] KIND_UNDEFINED = 5'd15;
   localparam logic [4:0] KIND_EOF       = 5'd16;

   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_PERIOD  = 8'h2E;
   localparam logic [7:0] CH_QMARK   = 8'h3F;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_VTAB    = 8'h0B;
   localparam logic [7:0] CH_FEED    = 8'h0C;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;

   // index 0 Schemes, 1 Facts, 2 Rules, 3 Queries
   localparam logic [3:0][55:0] KW_TEXT = {"Queries", {"Rules", 16'h0},
                                           {"Facts", 16'h0}, "Schemes"};
   localparam logic [3:0][2:0] KW_LEN = {3'd7, 3'd5, 3'd5, 3'd7};

   function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] pos);
      logic [2:0] slot;
      slot = 3'd6 - pos;
      return KW_TEXT[kw][{slot, 3'b000} +: 8];
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
             ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_alpha(c) || ((c >= CH_DIGIT_0) && (c <= CH_DIGIT_9));
   endfunction

endpackage
`default_nettype wire

FILE: design/dts_step.sv
// Lexer state and one-character step: mode, line and length counters, keyword mask.
// Produces up to two token beats per accepted character. Uses dts_pkg.
`default_nettype none
module dts_step #(
   parameter int COUNT_WIDTH = dts_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire dts_pkg::req_type req_beat,
   output dts_pkg::push_type     push
);

   localparam int CW = COUNT_WIDTH;

   dts_pkg::mode_type mode_ff, mode_in;
   logic [CW-1:0]     line_ff, line_in;
   logic [CW-1:0]     start_ff, start_in;
   logic [CW-1:0]     olen_ff, olen_in;
   logic [3:0]        mask_ff, mask_in;

   logic [7:0]        c;
   logic [3:0]        first_mask;
   logic [3:0]        add_mask;
   logic [4:0]        id_kind;

   logic              idle_tok_v;
   logic [4:0]        idle_kind;
   dts_pkg::mode_type idle_mode;
   logic              idle_start;
   logic [CW-1:0]     idle_olen;
   logic [3:0]        idle_mask;
   logic              idle_line;

   logic              use_idle;
   logic              pre_v;
   logic [4:0]        pre_kind;
   logic [CW-1:0]     pre_len;
   logic              post_v;
   logic [4:0]        post_kind;
   logic [CW-1:0]     post_line;
   logic [CW-1:0]     post_len;
   dts_pkg::rsp_type  pre_tok, post_tok;

   function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
      return (v == {CW{1'b1}}) ? v : v + CW'(1);
   endfunction

   function automatic logic [15:0] sat16(input logic [CW-1:0] v);
      return (v > CW'(16'hFFFF)) ? 16'hFFFF : 16'(v);
   endfunction

   assign c = req_beat.char_code;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         first_mask[i] = (dts_pkg::kw_char(2'(i), 3'd0) == c);
         add_mask[i]   = mask_ff[i] && (olen_ff < CW'(dts_pkg::KW_LEN[i])) &&
                         (dts_pkg::kw_char(2'(i), olen_ff[2:0]) == c);
      end
      id_kind = dts_pkg::KIND_ID;
      for (int i = 3; i >= 0; i--) begin
         if (mask_ff[i] && (olen_ff == CW'(dts_pkg::KW_LEN[i]))) begin
            id_kind = dts_pkg::KIND_SCHEMES + 5'(i);
         end
      end
   end

   // character seen from idle
   always_comb begin
      idle_tok_v = 1'b0;
      idle_kind  = dts_pkg::KIND_UNDEFINED;
      idle_mode  = dts_pkg::MODE_IDLE;
      idle_start = 1'b0;
      idle_olen  = olen_ff;
      idle_mask  = mask_ff;
      idle_line  = 1'b0;
      case (c)
         dts_pkg::CH_COMMA: begin
            idle_tok_v = 1'b1;
            idle_kind  = dts_pkg::KIND_COMMA;
         end
         dts_pkg::CH_PERIOD: begin
            idle_tok_v = 1'b1;
            idle_kind  = dts_pkg::KIND_PERIOD;
         end
         dts_pkg::CH_QMARK: begin
            idle_tok_v = 1'b1;
            idle_kind  = dts_pkg::KIND_QMARK;
         end
         dts_pkg::CH_LPAREN: begin
            idle_tok_v = 1'b1;
            idle_kind  = dts_pkg::KIND_LPAREN;
         end
         dts_pkg::CH_RPAREN: begin
            idle_tok_v = 1'b1;
            idle_kind  = dts_pkg::KIND_RPAREN;
         end
         dts_pkg::CH_STAR: begin
            idle_tok_v = 1'b1;
            idle_kind  = dts_pkg::KIND_MUL;
         end
         dts_pkg::CH_PLUS: begin
            idle_tok_v = 1'b1;
            idle_kind  = dts_pkg::KIND_ADD;
         end
         dts_pkg::CH_COLON: begin
            idle_mode  = dts_pkg::MODE_COLON;
            idle_start = 1'b1;
         end
         dts_pkg::CH_NEWLINE: begin
            idle_line = 1'b1;
         end
         dts_pkg::CH_SPACE, dts_pkg::CH_TAB, dts_pkg::CH_VTAB,
         dts_pkg::CH_FEED, dts_pkg::CH_CR: begin
            idle_mode = dts_pkg::MODE_IDLE;
         end
         dts_pkg::CH_HASH: begin
            idle_mode  = dts_pkg::MODE_HASH;
            idle_start = 1'b1;
            idle_olen  = CW'(1);
         end
         dts_pkg::CH_QUOTE: begin
            idle_mode  = dts_pkg::MODE_STR;
            idle_start = 1'b1;
            idle_olen  = CW'(1);
         end
         default: begin
            if (dts_pkg::is_alpha(c)) begin
               idle_mode  = dts_pkg::MODE_ID;
               idle_start = 1'b1;
               idle_olen  = CW'(1);
               idle_mask  = first_mask;
            end else begin
               idle_tok_v = 1'b1;
               idle_kind  = dts_pkg::KIND_UNDEFINED;
            end
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      start_in  = start_ff;
      olen_in   = olen_ff;
      mask_in   = mask_ff;
      use_idle  = 1'b0;
      pre_v     = 1'b0;
      pre_kind  = dts_pkg::KIND_UNDEFINED;
      pre_len   = olen_ff;
      post_v    = 1'b0;
      post_kind = dts_pkg::KIND_UNDEFINED;
      post_line = line_ff;
      post_len  = CW'(1);
      if (req_beat.end_of_input) begin
         case (mode_ff)
            dts_pkg::MODE_COLON: begin
               pre_v    = 1'b1;
               pre_kind = dts_pkg::KIND_COLON;
               pre_len  = CW'(1);
            end
            dts_pkg::MODE_ID: begin
               pre_v    = 1'b1;
               pre_kind = id_kind;
            end
            dts_pkg::MODE_QUOTE: begin
               pre_v    = 1'b1;
               pre_kind = dts_pkg::KIND_STRING;
            end
            dts_pkg::MODE_STR, dts_pkg::MODE_BLOCK, dts_pkg::MODE_BAR: begin
               pre_v    = 1'b1;
               pre_kind = dts_pkg::KIND_UNDEFINED;
            end
            default: begin
               pre_v = 1'b0;
            end
         endcase
         post_v    = 1'b1;
         post_kind = dts_pkg::KIND_EOF;
         post_len  = '0;
         mode_in   = dts_pkg::MODE_IDLE;
         line_in   = CW'(1);
         start_in  = CW'(1);
         olen_in   = '0;
         mask_in   = 4'hF;
      end else begin
         case (mode_ff)
            dts_pkg::MODE_COLON: begin
               mode_in = dts_pkg::MODE_IDLE;
               pre_v   = 1'b1;
               if (c == dts_pkg::CH_DASH) begin
                  pre_kind = dts_pkg::KIND_COLONDASH;
                  pre_len  = CW'(2);
               end else begin
                  pre_kind = dts_pkg::KIND_COLON;
                  pre_len  = CW'(1);
                  use_idle = 1'b1;
               end
            end
            dts_pkg::MODE_ID: begin
               if (dts_pkg::is_alnum(c)) begin
                  mask_in = add_mask;
                  olen_in = inc_sat(olen_ff);
               end else begin
                  mode_in  = dts_pkg::MODE_IDLE;
                  pre_v    = 1'b1;
                  pre_kind = id_kind;
                  use_idle = 1'b1;
               end
            end
            dts_pkg::MODE_HASH: begin
               if (c == dts_pkg::CH_BAR) begin
                  mode_in = dts_pkg::MODE_BLOCK;
                  olen_in = CW'(2);
               end else if (c == dts_pkg::CH_NEWLINE) begin
                  mode_in = dts_pkg::MODE_IDLE;
                  line_in = inc_sat(line_ff);
               end else begin
                  mode_in = dts_pkg::MODE_LINE;
               end
            end
            dts_pkg::MODE_LINE: begin
               if (c == dts_pkg::CH_NEWLINE) begin
                  mode_in = dts_pkg::MODE_IDLE;
                  line_in = inc_sat(line_ff);
               end
            end
            dts_pkg::MODE_BLOCK, dts_pkg::MODE_BAR: begin
               olen_in = inc_sat(olen_ff);
               if ((mode_ff == dts_pkg::MODE_BAR) && (c == dts_pkg::CH_HASH)) begin
                  mode_in = dts_pkg::MODE_IDLE;
               end else if (c == dts_pkg::CH_BAR) begin
                  mode_in = dts_pkg::MODE_BAR;
               end else begin
                  mode_in = dts_pkg::MODE_BLOCK;
                  if (c == dts_pkg::CH_NEWLINE) begin
                     line_in = inc_sat(line_ff);
                  end
               end
            end
            dts_pkg::MODE_STR: begin
               olen_in = inc_sat(olen_ff);
               if (c == dts_pkg::CH_NEWLINE) begin
                  line_in = inc_sat(line_ff);
               end else if (c == dts_pkg::CH_QUOTE) begin
                  mode_in = dts_pkg::MODE_QUOTE;
               end
            end
            dts_pkg::MODE_QUOTE: begin
               if (c == dts_pkg::CH_QUOTE) begin
                  olen_in = inc_sat(olen_ff);
                  mode_in = dts_pkg::MODE_STR;
               end else begin
                  mode_in  = dts_pkg::MODE_IDLE;
                  pre_v    = 1'b1;
                  pre_kind = dts_pkg::KIND_STRING;
                  use_idle = 1'b1;
               end
            end
            default: begin
               use_idle = 1'b1;
            end
         endcase
         if (use_idle) begin
            mode_in = idle_mode;
            olen_in = idle_olen;
            mask_in = idle_mask;
            post_v    = idle_tok_v;
            post_kind = idle_kind;
            if (idle_start) begin
               start_in = line_ff;
            end
            if (idle_line) begin
               line_in = inc_sat(line_ff);
            end
         end
      end
   end

   always_comb begin
      pre_tok.token_kind    = pre_kind;
      pre_tok.line_number   = sat16(start_ff);
      pre_tok.token_length  = sat16(pre_len);
      pre_tok.last_of_run   = !post_v;
      post_tok.token_kind   = post_kind;
      post_tok.line_number  = sat16(post_line);
      post_tok.token_length = sat16(post_len);
      post_tok.last_of_run  = 1'b1;
      if (pre_v) begin
         push.tok0 = pre_tok;
         push.tok1 = post_tok;
         push.num  = post_v ? 2'd2 : 2'd1;
      end else begin
         push.tok0 = post_tok;
         push.tok1 = post_tok;
         push.num  = post_v ? 2'd1 : 2'd0;
      end
      if (!accept) begin
         push.num = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= dts_pkg::MODE_IDLE;
         line_ff  <= CW'(1);
         start_ff <= CW'(1);
         olen_ff  <= '0;
         mask_ff  <= 4'hF;
      end else if (accept) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         start_ff <= start_in;
         olen_ff  <= olen_in;
         mask_ff  <= mask_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/dts_rsp_queue.sv
// Four-entry token queue between the lexer step and the result channel.
// Takes up to two beats per cycle, gives one while rsp is not stalled. Uses dts_pkg.
`default_nettype none
module dts_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dts_pkg::push_type push,
   output logic                   hold,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dts_pkg::rsp_type       rsp_beat
);

   dts_pkg::rsp_type              mem_ff [dts_pkg::QUEUE_DEPTH];
   logic [dts_pkg::QUEUE_AW-1:0]  wptr_ff, wptr_in;
   logic [dts_pkg::QUEUE_AW-1:0]  rptr_ff, rptr_in;
   logic [dts_pkg::QUEUE_AW-1:0]  count_ff, count_in;
   logic                          pop;

   assign rsp_valid = (count_ff != '0);
   assign hold      = (count_ff >= dts_pkg::QUEUE_AW'(2));
   assign rsp_beat  = mem_ff[rptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wptr_in  = wptr_ff + dts_pkg::QUEUE_AW'(push.num);
      rptr_in  = rptr_ff + dts_pkg::QUEUE_AW'(pop);
      count_in = count_ff + dts_pkg::QUEUE_AW'(push.num) - dts_pkg::QUEUE_AW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wptr_ff] <= push.tok0;
      end
      if (push.num == 2'd2) begin
         mem_ff[wptr_ff + dts_pkg::QUEUE_AW'(1)] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (push.num != 2'd0) |-> (count_ff < dts_pkg::QUEUE_AW'(2)))
      else $error("push into queue holding two or more beats");

   assert property (@(posedge clock) disable iff (reset)
      (pop && (push.num == 2'd0)) |=> (count_ff == $past(count_ff) - dts_pkg::QUEUE_AW'(1)))
      else $error("queue count did not drop on pop");

   assert property (@(posedge clock) disable iff (reset)
      (push.num == 2'd2) |-> (push.tok1.last_of_run && !push.tok0.last_of_run))
      else $error("wrong last_of_run on a two-token push");

   assert property (@(posedge clock) disable iff (reset)
      (push.num == 2'd1) |-> push.tok0.last_of_run)
      else $error("single token push without last_of_run");

endmodule
`default_nettype wire

FILE: design/datalog_token_scanner_core.sv
// Datalog token scanner top level: lexer step feeding a four-entry result queue.
// A token beat is written into the queue when its character is accepted; rsp offers the queue head.
// Throughput: one character per cycle while each gives at most one token and rsp drains;
// a character that releases two tokens stalls req until rsp has taken a beat, as the queue
// drains one beat per cycle and holds off req while it holds two or more beats.
// Reset (synchronous): mode idle, line 1, open length 0, queue empty.
`default_nettype none
module datalog_token_scanner_core #(
   parameter int COUNT_WIDTH = dts_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire dts_pkg::req_type req_beat,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output dts_pkg::rsp_type      rsp_beat
);

   dts_pkg::push_type push;
   logic              hold;
   logic              accept;

   assign req_stall = hold;
   assign accept    = req_valid && !hold;

   dts_step #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_step (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_beat (req_beat),
      .push     (push)
   );

   dts_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule
`default_nettype wire
